@@ hw/rtl/rcfm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rcfm_pkg
// Shared types and constants of the relay contact fault monitor.
// ----------------------------------------------------------------------------
package rcfm_pkg;

    localparam int unsigned HISTORY_BITS_DEFAULT = 16;
    localparam int unsigned SETTLE_WIDTH         = 16;
    localparam logic [SETTLE_WIDTH-1:0] SETTLE_TICKS_RESET = 16'd1000;

    typedef enum logic [1:0] {
        ST_UNKNOWN      = 2'd0,
        ST_OK           = 2'd1,
        ST_GROUND_FAULT = 2'd2,
        ST_STUCK_RELAY  = 2'd3
    } status_t;

    typedef struct packed {
        logic sense_a_n;
        logic sense_b_n;
        logic enable_request;
        logic check_request;
    } in_item_t;

    typedef struct packed {
        logic    relay_drive;
        status_t status;
        logic    ac_present;
        logic    charge_event;
    } out_item_t;

endpackage : rcfm_pkg
`default_nettype wire

@@ hw/rtl/rcfm_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rcfm_core
// Relay state, settle counter, sense history and status classification.
// The state advances by one tick whenever step is high.
// ----------------------------------------------------------------------------
module rcfm_core
    import rcfm_pkg::*;
#(
    parameter int unsigned HISTORY_BITS = HISTORY_BITS_DEFAULT
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    step,
    input  wire in_item_t                item,
    input  wire logic [SETTLE_WIDTH-1:0] settle_ticks,
    output out_item_t                    result
);

    status_t                   status_reg;
    status_t                   status_next;
    logic                      relays_on_reg;
    logic                      relays_on_next;
    logic [HISTORY_BITS-1:0]   hist_reg;
    logic [HISTORY_BITS-1:0]   hist_next;
    logic [SETTLE_WIDTH-1:0]   settle_reg;
    logic [SETTLE_WIDTH-1:0]   settle_next;
    logic                      change;
    logic                      sample;
    logic                      active;
    logic                      evaluate;

    always_comb
    begin
        change         = item.enable_request != relays_on_reg;
        relays_on_next = item.enable_request;
        if (change)
        begin
            settle_next = '0;
        end
        else if (settle_reg != '1)
        begin
            settle_next = settle_reg + SETTLE_WIDTH'(1);
        end
        else
        begin
            settle_next = settle_reg;
        end

        sample    = !item.sense_a_n || !item.sense_b_n;
        hist_next = {hist_reg[HISTORY_BITS-2:0], sample};
        active    = |hist_next;

        evaluate = item.check_request
                   && (status_reg == ST_UNKNOWN || status_reg == ST_OK)
                   && (settle_next >= settle_ticks);

        status_next = status_reg;
        if (evaluate)
        begin
            if (relays_on_next)
            begin
                status_next = active ? ST_OK : ST_GROUND_FAULT;
            end
            else
            begin
                status_next = active ? ST_STUCK_RELAY : ST_OK;
            end
        end

        result.relay_drive  = relays_on_next;
        result.status       = status_next;
        result.ac_present   = active;
        result.charge_event = change;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg    <= ST_UNKNOWN;
            relays_on_reg <= 1'b0;
            hist_reg      <= '0;
            settle_reg    <= '0;
        end
        else if (step)
        begin
            status_reg    <= status_next;
            relays_on_reg <= relays_on_next;
            hist_reg      <= hist_next;
            settle_reg    <= settle_next;
        end
    end

    // A fault, once reported, holds until reset.
    a_fault_latched: assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg == ST_GROUND_FAULT || status_reg == ST_STUCK_RELAY)
        |=> (status_reg == $past(status_reg)))
        else $error("relay fault status left its latched value");

    a_change_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && change) |=> (settle_reg == '0 && $fell(relays_on_reg) != $rose(relays_on_reg)))
        else $error("relay change did not clear the settle counter");

    a_settle_count: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !change && settle_reg != '1)
        |=> (settle_reg == $past(settle_reg) + SETTLE_WIDTH'(1)))
        else $error("settle counter did not advance");

    a_history_sample: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (hist_reg[0] == $past(!item.sense_a_n || !item.sense_b_n)))
        else $error("sense history did not take the new sample");

endmodule : rcfm_core
`default_nettype wire

@@ hw/rtl/relay_contact_fault_monitor_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// relay_contact_fault_monitor_unit
// An accepted item passes from the input register to the result register.
// Throughput: one item per cycle while out_ready does not stall the output,
// set by the single update of the relay state. Each register holds one item.
// Reset clears the relay state, history, settle counter and valid flags, and
// loads settle_ticks with 1000.
// ----------------------------------------------------------------------------
module relay_contact_fault_monitor_unit
    import rcfm_pkg::*;
#(
    parameter int unsigned HISTORY_BITS = HISTORY_BITS_DEFAULT
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire in_item_t                in_item,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output out_item_t                    out_item,
    input  wire logic                    cfg_we,
    input  wire logic [SETTLE_WIDTH-1:0] cfg_wdata
);

    logic [SETTLE_WIDTH-1:0] settle_ticks_reg;
    logic                    s1_valid_reg;
    in_item_t                s1_item_reg;
    logic                    out_valid_reg;
    out_item_t               out_item_reg;
    out_item_t               result;
    logic                    advance;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_ticks_reg <= SETTLE_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            settle_ticks_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_item;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    rcfm_core #(
        .HISTORY_BITS (HISTORY_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .item         (s1_item_reg),
        .settle_ticks (settle_ticks_reg),
        .result       (result)
    );

endmodule : relay_contact_fault_monitor_unit
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the relay contact fault monitor. A queue of tick items feeds a
// valid/ready driver, and a behavioural copy of the relay state predicts each
// result item. A monitor compares every result with the oldest prediction.
// The run covers a directed opening, randomised relay sequences under several
// settle times, a run under the longest settle time and a noisy close.
// ----------------------------------------------------------------------------
module tb_top
    import rcfm_pkg::*;
();

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    in_item_t                in_item   = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    out_item_t               out_item;
    logic                    cfg_we    = 1'b0;
    logic [SETTLE_WIDTH-1:0] cfg_wdata = '0;

    relay_contact_fault_monitor_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    in_item_t  pending_ticks[$];
    out_item_t predicted_reports[$];

    logic                            p_relays_on    = 1'b0;
    status_t                         p_status       = ST_UNKNOWN;
    logic [HISTORY_BITS_DEFAULT-1:0] p_history      = '0;
    logic [SETTLE_WIDTH-1:0]         p_settle_cnt   = '0;
    logic [SETTLE_WIDTH-1:0]         p_settle_ticks = SETTLE_TICKS_RESET;

    bit        idling_on   = 1'b1;
    bit        req_level   = 1'b0;
    int        quiet_ticks = HISTORY_BITS_DEFAULT;
    int        in_gap      = 0;
    int        out_gap     = 0;
    int        mismatches  = 0;
    out_item_t want;

    initial forever #2 clk = ~clk;

    task automatic predict_tick(input in_item_t it);
        out_item_t r;
        logic      ac;
        r.charge_event = 1'b0;
        if (it.enable_request != p_relays_on)
        begin
            p_relays_on    = it.enable_request;
            p_settle_cnt   = '0;
            r.charge_event = 1'b1;
        end
        else if (p_settle_cnt != '1)
        begin
            p_settle_cnt = p_settle_cnt + 1'b1;
        end
        ac        = !it.sense_a_n || !it.sense_b_n;
        p_history = {p_history[HISTORY_BITS_DEFAULT-2:0], ac};
        if (it.check_request && (p_status == ST_UNKNOWN || p_status == ST_OK)
            && p_settle_cnt >= p_settle_ticks)
        begin
            if (p_relays_on)
                p_status = (p_history != '0) ? ST_OK : ST_GROUND_FAULT;
            else
                p_status = (p_history != '0) ? ST_STUCK_RELAY : ST_OK;
        end
        r.relay_drive = p_relays_on;
        r.status      = p_status;
        r.ac_present  = (p_history != '0);
        predicted_reports.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
            in_gap   = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_tick(in_item);
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (idling_on && pending_ticks.size() != 0
                         && $urandom_range(0, 9) == 0)
                begin
                    in_gap   = $urandom_range(0, 10);
                    in_valid <= 1'b0;
                end
                else if (pending_ticks.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_item  <= pending_ticks.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_reports.size() == 0)
                begin
                    $error("result item with no prediction waiting");
                    mismatches++;
                end
                else
                begin
                    want = predicted_reports.pop_front();
                    if (out_item.relay_drive !== want.relay_drive)
                    begin
                        $error("relay_drive: expected %0d, actual %0d",
                               want.relay_drive, out_item.relay_drive);
                        mismatches++;
                    end
                    if (out_item.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               want.status, out_item.status);
                        mismatches++;
                    end
                    if (out_item.ac_present !== want.ac_present)
                    begin
                        $error("ac_present: expected %0d, actual %0d",
                               want.ac_present, out_item.ac_present);
                        mismatches++;
                    end
                    if (out_item.charge_event !== want.charge_event)
                    begin
                        $error("charge_event: expected %0d, actual %0d",
                               want.charge_event, out_item.charge_event);
                        mismatches++;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 9) == 0)
            begin
                out_gap   = $urandom_range(0, 10);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic push_item(input in_item_t it);
        req_level = it.enable_request;
        if (!it.sense_a_n || !it.sense_b_n)
            quiet_ticks = 0;
        else if (quiet_ticks < 100)
            quiet_ticks++;
        pending_ticks.push_back(it);
    endtask

    // In guarded mode a check is only requested where the contacts look
    // healthy, so the status stays at unknown or ok and keeps evaluating.
    task automatic push_ticks(input int count, input bit guarded, input int check_pct,
                              input int noise_pct, input int flip_pct);
        in_item_t   it;
        logic [1:0] pins;
        int         quiet_after;
        bit         allowed;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 99) < flip_pct)
                req_level = !req_level;
            if ($urandom_range(0, 99) < noise_pct)
            begin
                it = in_item_t'(4'($urandom_range(0, 15)));
            end
            else
            begin
                it.enable_request = req_level;
                if (!req_level)
                    pins = 2'b11;
                else if (quiet_ticks < 10 && $urandom_range(0, 5) == 0)
                    pins = 2'b11;
                else
                    pins = 2'($urandom_range(0, 2));
                {it.sense_a_n, it.sense_b_n} = pins;
                it.check_request = ($urandom_range(0, 99) < check_pct);
            end
            if (guarded)
            begin
                quiet_after = (!it.sense_a_n || !it.sense_b_n) ? 0 : quiet_ticks + 1;
                allowed     = it.enable_request ? (quiet_after < HISTORY_BITS_DEFAULT)
                                                : (quiet_after >= HISTORY_BITS_DEFAULT);
                if (!allowed)
                    it.check_request = 1'b0;
            end
            push_item(it);
        end
    endtask

    task automatic wait_drain();
        do
            @(negedge clk);
        while (pending_ticks.size() != 0 || in_valid || predicted_reports.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_settle(input logic [SETTLE_WIDTH-1:0] ticks);
        @(posedge clk);
        cfg_we         <= 1'b1;
        cfg_wdata      <= ticks;
        p_settle_ticks = ticks;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int unsigned settle_set[7] = '{1, 2, 3, 5, 16, 37, 300};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Order of bits: sense_a_n, sense_b_n, enable_request, check_request.
        push_item(in_item_t'(4'b1101));
        push_item(in_item_t'(4'b0000));
        push_item(in_item_t'(4'b0110));
        push_item(in_item_t'(4'b1011));
        push_item(in_item_t'(4'b1110));
        push_item(in_item_t'(4'b1101));
        push_item(in_item_t'(4'b0100));
        push_item(in_item_t'(4'b1000));
        wait_drain();

        write_settle('0);
        push_item(in_item_t'(4'b0011));
        push_item(in_item_t'(4'b1111));
        push_item(in_item_t'(4'b0111));
        push_item(in_item_t'(4'b1100));
        wait_drain();

        foreach (settle_set[s])
        begin
            write_settle(SETTLE_WIDTH'(settle_set[s]));
            push_ticks(140, 1'b1, 25, 8, 4);
            wait_drain();
        end

        idling_on = 1'b0;
        write_settle('1);
        push_ticks(12, 1'b1, 100, 0, 0);
        wait_drain();

        write_settle(SETTLE_WIDTH'($urandom_range(0, 24)));
        push_ticks(150, 1'b0, 30, 40, 8);
        wait_drain();

        repeat (8) @(negedge clk);
        if (predicted_reports.size() != 0)
        begin
            $error("%0d predicted result items never arrived", predicted_reports.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule : tb_top
